// ===== src/fqd_pkg.sv =====
// ----------------------------------------------------------------------------
// fqd_pkg
// Types and codes shared by the handle queue and its storage cells.
// ----------------------------------------------------------------------------
`default_nettype none

package fqd_pkg;

   localparam int ValueWidth = 32;
   localparam int CountWidth = 5;

   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_DELETE  = 2'd2,
      OP_ITERATE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_COMPARE,
      CMD_LOAD,
      CMD_SHIFT,
      CMD_DELETE,
      CMD_ROTATE
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ITER
   } state_type;

   typedef struct packed {
      logic [1:0]            operation;
      logic [ValueWidth-1:0] handle_value;
   } req_word_type;

   typedef struct packed {
      logic                  status;
      logic [ValueWidth-1:0] entry_value;
      logic                  entry_valid;
      logic [CountWidth-1:0] item_count;
      logic                  last;
   } rsp_word_type;

endpackage

`default_nettype wire

// ===== src/fqd_cell.sv =====
// ----------------------------------------------------------------------------
// fqd_cell
// One queue slot: holds a handle, compares it, and takes its neighbor's
// handle on shift, delete and rotate.
// ----------------------------------------------------------------------------
`default_nettype none

module fqd_cell #(
   parameter int IDX          = 0,
   parameter int COUNT_WIDTH  = 5,
   parameter int HANDLE_WIDTH = 32
) (
   input  wire logic                       clock,
   input  wire fqd_pkg::cell_cmd_type      cmd,
   input  wire logic [COUNT_WIDTH-1:0]     count,
   input  wire logic [HANDLE_WIDTH-1:0]    handle,
   input  wire logic [HANDLE_WIDTH-1:0]    next_value,
   input  wire logic [HANDLE_WIDTH-1:0]    head_value,
   input  wire logic                       seen_in,
   output logic [HANDLE_WIDTH-1:0]         value_out,
   output logic                            seen_out
);
   import fqd_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] MyIdx = COUNT_WIDTH'(IDX);

   logic [HANDLE_WIDTH-1:0] value_ff, value_in;
   logic                    match_ff, match_in;
   logic                    occupied;

   assign occupied  = MyIdx < count;
   assign seen_out  = seen_in | match_ff;
   assign value_out = value_ff;

   always_comb begin
      value_in = value_ff;
      match_in = match_ff;
      case (cmd)
         CMD_COMPARE: match_in = occupied && (value_ff == handle);
         CMD_LOAD: begin
            if (MyIdx == count) value_in = handle;
         end
         CMD_SHIFT:  value_in = next_value;
         CMD_DELETE: begin
            if (seen_out) value_in = next_value;
         end
         CMD_ROTATE: begin
            if (MyIdx == count - COUNT_WIDTH'(1)) value_in = head_value;
            else value_in = next_value;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      match_ff <= match_in;
   end

endmodule

`default_nettype wire

// ===== src/fifo_queue_with_delete.sv =====
// ----------------------------------------------------------------------------
// fifo_queue_with_delete
// Bounded FIFO of nonzero handles with enqueue, dequeue, delete by value
// and iterate, built as a compacted row of slot cells, oldest at slot 0.
//
//   channel | direction | handshake               | word
//   req     | in        | req_valid / req_ready   | req_word_type
//   rsp     | out       | rsp_valid / rsp_ready   | rsp_word_type
//
// An item is taken in idle (all slots compare against the handle in that
// cycle) and executed in the exec state once the response slot is free.
// Iterate streams out the N stored handles: the row rotates one slot per
// cycle while rsp is not stalled, and slot 0 is streamed out.
// Reset clears the count and the controller; slot contents need no reset.
// A stalled rsp holds the controller; req is taken while a word still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_queue_with_delete #(
   parameter int QUEUE_DEPTH  = 16,
   parameter int HANDLE_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire fqd_pkg::req_word_type  req_word,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output fqd_pkg::rsp_word_type       rsp_word
);
   import fqd_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam logic [CW-1:0] FullCount = CW'(QUEUE_DEPTH);

   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;
   logic [HANDLE_WIDTH-1:0] handle_ff, handle_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [IW-1:0]          iter_ff, iter_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_word_ff, rsp_word_in;

   cell_cmd_type            cmd;
   logic [HANDLE_WIDTH-1:0] req_handle, cell_handle;
   logic [HANDLE_WIDTH-1:0] cell_value [QUEUE_DEPTH];
   logic                    seen [QUEUE_DEPTH+1];
   logic                    slot_free, found, iter_last;
   logic [HANDLE_WIDTH+ValueWidth-1:0] req_wide, head_wide;
   logic [CW+CountWidth-1:0] count_wide_now, count_wide_inc, count_wide_dec;
   logic [ValueWidth-1:0]   head_out;

   assign req_wide   = {{HANDLE_WIDTH{1'b0}}, req_word.handle_value};
   assign req_handle = req_wide[HANDLE_WIDTH-1:0];
   assign head_wide  = {{ValueWidth{1'b0}}, cell_value[0]};
   assign head_out   = head_wide[ValueWidth-1:0];

   assign count_wide_now = {{CountWidth{1'b0}}, count_ff};
   assign count_wide_inc = {{CountWidth{1'b0}}, count_ff + CW'(1)};
   assign count_wide_dec = {{CountWidth{1'b0}}, count_ff - CW'(1)};

   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign found       = seen[QUEUE_DEPTH];
   assign iter_last   = {1'b0, iter_ff} == count_ff - CW'(1);
   assign cell_handle = (state_ff == ST_IDLE) ? req_handle : handle_ff;
   assign seen[0]     = 1'b0;

   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic [HANDLE_WIDTH-1:0] nbr;
      if (g == QUEUE_DEPTH - 1) begin : g_end
         assign nbr = cell_value[g];
      end else begin : g_mid
         assign nbr = cell_value[g+1];
      end
      fqd_cell #(
         .IDX          (g),
         .COUNT_WIDTH  (CW),
         .HANDLE_WIDTH (HANDLE_WIDTH)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .count      (count_ff),
         .handle     (cell_handle),
         .next_value (nbr),
         .head_value (cell_value[0]),
         .seen_in    (seen[g]),
         .value_out  (cell_value[g]),
         .seen_out   (seen[g+1])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (op_ff == OP_ITERATE && count_ff != '0) state_in = ST_ITER;
            else if (slot_free) state_in = ST_IDLE;
         end
         ST_ITER: begin
            if (slot_free && iter_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_ready    = 1'b0;
      cmd          = CMD_HOLD;
      op_in        = op_ff;
      handle_in    = handle_ff;
      count_in     = count_ff;
      iter_in      = iter_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd       = CMD_COMPARE;
               op_in     = op_type'(req_word.operation);
               handle_in = req_handle;
            end
         end
         ST_EXEC: begin
            iter_in = '0;
            if (slot_free && !(op_ff == OP_ITERATE && count_ff != '0)) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = '{status: 1'b1, entry_value: '0, entry_valid: 1'b0,
                                item_count: count_wide_now[CountWidth-1:0],
                                last: 1'b1};
               case (op_ff)
                  OP_ENQUEUE: begin
                     if (handle_ff != '0 && count_ff != FullCount) begin
                        cmd                    = CMD_LOAD;
                        count_in               = count_ff + CW'(1);
                        rsp_word_in.status     = 1'b0;
                        rsp_word_in.item_count = count_wide_inc[CountWidth-1:0];
                     end
                  end
                  OP_DEQUEUE: begin
                     if (count_ff != '0) begin
                        cmd                     = CMD_SHIFT;
                        count_in                = count_ff - CW'(1);
                        rsp_word_in.status      = 1'b0;
                        rsp_word_in.entry_value = head_out;
                        rsp_word_in.entry_valid = 1'b1;
                        rsp_word_in.item_count  = count_wide_dec[CountWidth-1:0];
                     end
                  end
                  OP_DELETE: begin
                     if (handle_ff != '0 && found) begin
                        cmd                    = CMD_DELETE;
                        count_in               = count_ff - CW'(1);
                        rsp_word_in.status     = 1'b0;
                        rsp_word_in.item_count = count_wide_dec[CountWidth-1:0];
                     end
                  end
                  OP_ITERATE: rsp_word_in.status = 1'b0;
                  default: ;
               endcase
            end
         end
         ST_ITER: begin
            if (slot_free) begin
               cmd          = CMD_ROTATE;
               iter_in      = iter_ff + IW'(1);
               rsp_valid_in = 1'b1;
               rsp_word_in  = '{status: 1'b0, entry_value: head_out, entry_valid: 1'b1,
                                item_count: count_wide_now[CountWidth-1:0],
                                last: iter_last};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      handle_ff   <= handle_in;
      iter_ff     <= iter_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

// ===== tb/fifo_queue_with_delete_tb.sv =====
// ----------------------------------------------------------------------------
// fifo_queue_with_delete_tb
// Drives enqueue, dequeue, delete and iterate words into the handle queue.
// Each result word is checked against a queue model kept in the bench.
// A short table covers the error cases, duplicates and iterate, then a full queue.
// Random traffic then runs in fill, drain and mixed phases, with bursty
// requests and a stalling response side.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_queue_with_delete_tb;

   import fqd_pkg::*;

   localparam int Depth = 16;

   typedef struct {
      op_type       op;
      logic [31:0]  handle;
      bit           typed;
      rsp_word_type rsp;
   } directed_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   logic [31:0]      handle_model_q[$];
   rsp_word_type     pending_rsp_q[$];
   rsp_word_type     want;
   directed_row_type dir_table[14];
   logic [31:0]      handle_pool[6];
   bit [9:0]         ready_tick = '0;
   int               errors = 0;
   int               burst_left = 0;

   fifo_queue_with_delete DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

   function automatic void push_rsp(logic st, logic [31:0] value, logic valid, logic fin);
      rsp_word_type r;
      r.status      = st;
      r.entry_value = value;
      r.entry_valid = valid;
      r.item_count  = CountWidth'(handle_model_q.size());
      r.last        = fin;
      pending_rsp_q.push_back(r);
   endfunction

   // queue model: updates the stored handles and queues the words they cause
   function automatic void apply_op(op_type op, logic [31:0] h);
      logic [31:0] v;
      int          hit;
      hit = -1;
      case (op)
         OP_ENQUEUE: begin
            if (h == '0 || handle_model_q.size() >= Depth) begin
               push_rsp(1'b1, '0, 1'b0, 1'b1);
            end else begin
               handle_model_q.push_back(h);
               push_rsp(1'b0, '0, 1'b0, 1'b1);
            end
         end
         OP_DEQUEUE: begin
            if (handle_model_q.size() == 0) begin
               push_rsp(1'b1, '0, 1'b0, 1'b1);
            end else begin
               v = handle_model_q.pop_front();
               push_rsp(1'b0, v, 1'b1, 1'b1);
            end
         end
         OP_DELETE: begin
            if (h != '0) begin
               for (int i = 0; i < handle_model_q.size(); i++) begin
                  if (hit < 0 && handle_model_q[i] == h) hit = i;
               end
            end
            if (hit < 0) begin
               push_rsp(1'b1, '0, 1'b0, 1'b1);
            end else begin
               handle_model_q.delete(hit);
               push_rsp(1'b0, '0, 1'b0, 1'b1);
            end
         end
         default: begin
            if (handle_model_q.size() == 0) begin
               push_rsp(1'b0, '0, 1'b0, 1'b1);
            end else begin
               for (int i = 0; i < handle_model_q.size(); i++) begin
                  push_rsp(1'b0, handle_model_q[i], 1'b1,
                           i == handle_model_q.size() - 1);
               end
            end
         end
      endcase
   endfunction

   task automatic send_word(op_type op, logic [31:0] h, bit typed = 0,
                            rsp_word_type typed_rsp = '0);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
      req_valid          <= 1'b1;
      req_word.operation <= op;
      req_word.handle_value <= h;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      apply_op(op, h);
      if (typed) begin
         void'(pending_rsp_q.pop_back());
         pending_rsp_q.push_back(typed_rsp);
      end
   endtask

   task automatic wait_drained();
      while (pending_rsp_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_handle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) return '0;
      if (r < 35) return handle_pool[$urandom_range(0, 5)];
      return $urandom();
   endfunction

   task automatic note_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (exp_val !== act_val) begin
         errors++;
         if (errors < 40) begin
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, name, exp_val, act_val);
         end
      end
   endtask

   // response side stalls on its own rotating pattern
   always @(posedge clock) begin
      ready_tick <= ready_tick + 1'b1;
      case (ready_tick[9:8])
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= ($urandom_range(0, 1) == 1);
         2'd2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= (ready_tick[2:0] != 3'd5);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp_q.size() == 0) begin
            errors++;
            if (errors < 40) begin
               $display("%0t: unexpected word, expected none, actual %p", $time, rsp_word);
            end
         end else begin
            want = pending_rsp_q.pop_front();
            note_field("status", want.status, rsp_word.status);
            note_field("entry_value", want.entry_value, rsp_word.entry_value);
            note_field("entry_valid", want.entry_valid, rsp_word.entry_valid);
            note_field("item_count", want.item_count, rsp_word.item_count);
            note_field("last", want.last, rsp_word.last);
         end
      end
   end

   initial begin
      int          mode;
      int          r;
      op_type      op;
      logic [31:0] h;

      handle_pool = '{32'h0000_0001, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
                      32'h5555_5555, 32'h8000_0000, 32'h0000_00FF};

      dir_table[0]  = '{OP_DEQUEUE, 32'h0, 1, '{1'b1, 32'h0, 1'b0, 5'd0, 1'b1}};
      dir_table[1]  = '{OP_ITERATE, 32'h0, 1, '{1'b0, 32'h0, 1'b0, 5'd0, 1'b1}};
      dir_table[2]  = '{OP_DELETE, 32'h5, 1, '{1'b1, 32'h0, 1'b0, 5'd0, 1'b1}};
      dir_table[3]  = '{OP_ENQUEUE, 32'h0, 1, '{1'b1, 32'h0, 1'b0, 5'd0, 1'b1}};
      dir_table[4]  = '{OP_DELETE, 32'h0, 1, '{1'b1, 32'h0, 1'b0, 5'd0, 1'b1}};
      dir_table[5]  = '{OP_ENQUEUE, 32'hFFFF_FFFF, 1, '{1'b0, 32'h0, 1'b0, 5'd1, 1'b1}};
      dir_table[6]  = '{OP_ENQUEUE, 32'h1, 1, '{1'b0, 32'h0, 1'b0, 5'd2, 1'b1}};
      dir_table[7]  = '{OP_ENQUEUE, 32'hAAAA_AAAA, 0, '0};
      dir_table[8]  = '{OP_ENQUEUE, 32'h5555_5555, 0, '0};
      dir_table[9]  = '{OP_ENQUEUE, 32'h1, 0, '0};
      dir_table[10] = '{OP_DELETE, 32'h1, 0, '0};
      dir_table[11] = '{OP_ITERATE, 32'h0, 0, '0};
      dir_table[12] = '{OP_DELETE, 32'h1234_5678, 0, '0};
      dir_table[13] = '{OP_DEQUEUE, 32'hDEAD_BEEF, 0, '0};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) begin
         send_word(dir_table[i].op, dir_table[i].handle, dir_table[i].typed, dir_table[i].rsp);
      end

      // full queue: overflow, full iterate, delete at the tail and in the middle
      while (handle_model_q.size() < Depth) send_word(OP_ENQUEUE, pick_handle() | 32'h1);
      send_word(OP_ENQUEUE, 32'h7);
      send_word(OP_ITERATE, 32'h0);
      send_word(OP_DELETE, handle_model_q[Depth-1]);
      send_word(OP_DELETE, handle_model_q[7]);
      send_word(OP_ITERATE, 32'h0);

      mode = 0;
      for (int n = 0; n < 200; n++) begin
         if (n % 30 == 0) mode = $urandom_range(0, 2);
         if (n == 100) begin
            req_valid <= 1'b0;
            wait_drained();
         end
         r = $urandom_range(0, 99);
         case (mode)
            0: op = (r < 70) ? OP_ENQUEUE : (r < 82) ? OP_DEQUEUE :
                    (r < 92) ? OP_DELETE : OP_ITERATE;
            1: op = (r < 20) ? OP_ENQUEUE : (r < 55) ? OP_DEQUEUE :
                    (r < 90) ? OP_DELETE : OP_ITERATE;
            default: op = op_type'(r[1:0]);
         endcase
         h = pick_handle();
         if (op == OP_DELETE && handle_model_q.size() != 0 && $urandom_range(0, 9) < 6) begin
            h = handle_model_q[$urandom_range(0, handle_model_q.size() - 1)];
         end
         send_word(op, h);
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
